// ----- hdl/fbs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbs_pkg
// Shared widths, register indexes and reset values for the FIFO-fed bit
// serialiser with hysteresis flow control.
// ----------------------------------------------------------------------------
package fbs_pkg;

  localparam int unsigned LevelW  = 9;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 9;
  localparam int unsigned BitCntW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STOP_LEVEL   = 2'd0,
    REG_PAUSE_LEVEL  = 2'd1,
    REG_RESUME_LEVEL = 2'd2,
    REG_INVERT_BITS  = 2'd3
  } cfg_reg_e;

  localparam logic [LevelW-1:0]  StopLevelRst   = 9'd125;
  localparam logic [LevelW-1:0]  PauseLevelRst  = 9'd160;
  localparam logic [LevelW-1:0]  ResumeLevelRst = 9'd120;
  localparam logic [BitCntW-1:0] BitsPerByte    = 4'd8;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

endpackage : fbs_pkg
`default_nettype wire

// ----- hdl/fbs_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fbs_if
// Valid/ready channels of the serialiser: input beats, result beats and
// register writes.
// ----------------------------------------------------------------------------
interface fbs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [fbs_pkg::ByteW-1:0]   data_byte;
  logic                        host_key_request;

  modport source (output valid, action, data_byte, host_key_request, input ready);
  modport sink   (input valid, action, data_byte, host_key_request, output ready);
endinterface : fbs_in_if

interface fbs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        send_enable;
  logic                        transmit_key;
  logic                        data_level;
  logic                        bit_strobe;
  logic                        byte_refused;
  logic [fbs_pkg::LevelW-1:0]  fill_count;

  modport source (output valid, send_enable, transmit_key, data_level, bit_strobe,
                  byte_refused, fill_count, input ready);
  modport sink   (input valid, send_enable, transmit_key, data_level, bit_strobe,
                  byte_refused, fill_count, output ready);
endinterface : fbs_out_if

interface fbs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fbs_pkg::CfgIdxW-1:0]  index;
  logic [fbs_pkg::CfgDatW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface : fbs_cfg_if
`default_nettype wire

// ----- hdl/fifo_bit_serializer_flow_ctrl.sv -----
`default_nettype none
// A result beat passes the s1 register and then the output register.
// Throughput: one beat per cycle while out_o is ready; the byte store is read and
// written once a cycle at most, and the pop read data lands in the result stage.
// Reset: pointers, count, shift state and flags clear at once (send permission
// and line level set); the byte store has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
// fifo_bit_serializer_flow_ctrl
// Byte FIFO in a synchronous RAM, MSB-first bit serialiser driven by tick
// beats, and hysteresis flow control towards the host.
// ----------------------------------------------------------------------------
module fifo_bit_serializer_flow_ctrl #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fbs_in_if.sink     in_i,
  fbs_out_if.source  out_o,
  fbs_cfg_if.sink    cfg_i
);

  localparam int unsigned PtrW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntRW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CntW  = (CntRW > fbs_pkg::LevelW) ? CntRW : fbs_pkg::LevelW;

  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);

  // Result stage contents, waiting on the RAM read for a popping tick.
  typedef struct packed {
    logic                        send;
    logic                        key;
    logic                        line;
    logic                        use_mem;   // line comes from the byte just popped
    logic                        strobe;
    logic                        refused;
    logic [fbs_pkg::LevelW-1:0]  fill;
  } stage_t;

  // ---------------------------------------------------------------- registers
  logic [fbs_pkg::LevelW-1:0] stop_q, pause_q, resume_q;
  logic                       invert_q;

  logic [PtrW-1:0]             rp_q, rp_d, wp_q, wp_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [fbs_pkg::ByteW-1:0]   shift_q, shift_d;
  logic                        fresh_q, fresh_d;    // shift byte still sits in rdata_q
  logic [fbs_pkg::BitCntW-1:0] bits_q, bits_d;
  logic                        paused_q, paused_d;
  logic                        send_q, send_d;
  logic                        key_q, key_d;
  logic                        line_q, line_d;
  logic                        line_mem_q, line_mem_d;  // held line taken from rdata_q

  logic                        s1_valid_q;
  stage_t                      s1_q, s1_d;
  logic                        out_valid_q;
  stage_t                      out_q;
  logic                        out_line_q;

  // Byte store
  logic [fbs_pkg::ByteW-1:0]   mem_q [FIFO_DEPTH];
  logic [fbs_pkg::ByteW-1:0]   rdata_q;
  logic                        mem_we, mem_re;

  // ---------------------------------------------------------------- handshake
  logic in_acc, s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // ---------------------------------------------------------------- item logic
  logic [fbs_pkg::ByteW-1:0] cur_byte;
  logic                      held_line;
  logic                      resume_ok;
  logic                      pop;
  logic [2:0]                bit_idx;

  assign cur_byte  = fresh_q ? rdata_q : shift_q;
  assign held_line = line_mem_q ? ~(rdata_q[fbs_pkg::ByteW-1] ^ invert_q) : line_q;
  assign resume_ok = (cnt_q <= CntW'(resume_q));
  assign pop       = (bits_q == '0) && (cnt_q != '0);
  assign bit_idx   = 3'(bits_q - 4'd1);

  always_comb begin
    rp_d       = rp_q;
    wp_d       = wp_q;
    cnt_d      = cnt_q;
    bits_d     = bits_q;
    paused_d   = paused_q;
    send_d     = send_q;
    key_d      = key_q;
    // the popped MSB settles into line_q the cycle after the read
    line_d     = held_line;
    line_mem_d = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    s1_d       = '0;

    if (in_acc) begin
      if (in_i.action == fbs_pkg::ACT_BYTE) begin
        s1_d.line = held_line;
        if (cnt_q >= CntFull) begin
          send_d       = 1'b0;
          s1_d.refused = 1'b1;
        end else if (paused_q && !resume_ok) begin
          s1_d.refused = 1'b1;
        end else begin
          mem_we   = 1'b1;
          wp_d     = (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
          cnt_d    = cnt_q + 1'b1;
          send_d   = !(cnt_q >= CntW'(stop_q));
          paused_d = (cnt_q >= CntW'(pause_q));
        end
      end else begin
        key_d = (bits_q != '0) || (cnt_q != '0) || in_i.host_key_request;
        if (pop) begin
          // MSB of the popped byte leaves now; its value arrives with the read
          mem_re       = 1'b1;
          rp_d         = (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
          cnt_d        = cnt_q - 1'b1;
          bits_d       = fbs_pkg::BitsPerByte - 4'd1;
          line_mem_d   = 1'b1;
          s1_d.use_mem = 1'b1;
          s1_d.strobe  = 1'b1;
        end else if (bits_q != '0) begin
          line_d      = ~(cur_byte[bit_idx] ^ invert_q);
          line_mem_d  = 1'b0;
          bits_d      = bits_q - 4'd1;
          s1_d.strobe = 1'b1;
        end else begin
          line_d     = 1'b1;
          line_mem_d = 1'b0;
        end
        s1_d.line = line_d;
        if (paused_q && (cnt_d <= CntW'(resume_q))) begin
          paused_d = 1'b0;
          send_d   = 1'b1;
        end
      end
      s1_d.send = send_d;
      s1_d.key  = key_d;
      s1_d.fill = cnt_d[fbs_pkg::LevelW-1:0];
    end
  end

  // Shift byte moves out of the RAM read register the cycle after a pop.
  assign shift_d = fresh_q ? rdata_q : shift_q;
  assign fresh_d = in_acc && (in_i.action == fbs_pkg::ACT_TICK) && pop;

  // ---------------------------------------------------------------- byte store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= in_i.data_byte;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rp_q];
    end
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q       <= '0;
      wp_q       <= '0;
      cnt_q      <= '0;
      shift_q    <= '0;
      fresh_q    <= 1'b0;
      bits_q     <= '0;
      paused_q   <= 1'b0;
      send_q     <= 1'b1;
      key_q      <= 1'b0;
      line_q     <= 1'b1;
      line_mem_q <= 1'b0;
    end else begin
      rp_q       <= rp_d;
      wp_q       <= wp_d;
      cnt_q      <= cnt_d;
      shift_q    <= shift_d;
      fresh_q    <= fresh_d;
      bits_q     <= bits_d;
      paused_q   <= paused_d;
      send_q     <= send_d;
      key_q      <= key_d;
      line_q     <= line_d;
      line_mem_q <= line_mem_d;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q   <= fbs_pkg::StopLevelRst;
      pause_q  <= fbs_pkg::PauseLevelRst;
      resume_q <= fbs_pkg::ResumeLevelRst;
      invert_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        fbs_pkg::REG_STOP_LEVEL:   stop_q   <= cfg_i.data;
        fbs_pkg::REG_PAUSE_LEVEL:  pause_q  <= cfg_i.data;
        fbs_pkg::REG_RESUME_LEVEL: resume_q <= cfg_i.data;
        fbs_pkg::REG_INVERT_BITS:  invert_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // rdata_q holds while the stage waits: no pop is taken until it moves on.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q      <= s1_q;
      out_line_q <= s1_q.use_mem ? ~(rdata_q[fbs_pkg::ByteW-1] ^ invert_q) : s1_q.line;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.send_enable  = out_q.send;
  assign out_o.transmit_key = out_q.key;
  assign out_o.data_level   = out_line_q;
  assign out_o.bit_strobe   = out_q.strobe;
  assign out_o.byte_refused = out_q.refused;
  assign out_o.fill_count   = out_q.fill;

endmodule : fifo_bit_serializer_flow_ctrl
`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FIFO-fed bit serialiser. A local model of the
// byte queue, shifter and flow control predicts every result beat; a short
// table of directed beats and register writes runs first, then a byte-fill
// phase and random phases under several level settings, with random gaps on
// both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned FifoDepth = 256;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseBeats = 140;

  // one result beat, field for field
  typedef struct packed {
    logic                       send_enable;
    logic                       transmit_key;
    logic                       data_level;
    logic                       bit_strobe;
    logic                       byte_refused;
    logic [fbs_pkg::LevelW-1:0] fill_count;
  } serial_res_t;

  typedef enum logic {
    ROW_BEAT = 1'b0,
    ROW_REG  = 1'b1
  } row_kind_e;

  // directed table: either an input beat or a register write
  typedef struct packed {
    row_kind_e                   kind;
    fbs_pkg::cfg_reg_e           reg_idx;
    logic [fbs_pkg::CfgDatW-1:0] reg_val;
    fbs_pkg::action_e            act;
    logic [fbs_pkg::ByteW-1:0]   data;
    logic                        hk;
    logic                        typed;
    serial_res_t                 want;
  } stim_row_t;

  localparam serial_res_t NoWant = '0;
  localparam int unsigned NumRows = 25;

  // Typed results are for the first beats after reset, where levels are at
  // their defaults and the queue is nearly empty. Everything else is left to
  // the local model.
  localparam stim_row_t StimTable [NumRows] = '{
    // idle tick straight out of reset, no key request
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b1,
      '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 9'd0}},
    // idle tick with key request: key up, line stays high
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_TICK, 8'h00, 1'b1, 1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 9'd0}},
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_BYTE, 8'hFF, 1'b0, 1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 9'd1}},
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_BYTE, 8'h00, 1'b1, 1'b1,
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 9'd2}},
    // pop of 0xFF, MSB set drives the line low
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 9'd1}},
    // wide write, masks down to invert on
    '{ROW_REG,  fbs_pkg::REG_INVERT_BITS, 9'h1FF, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0,
      NoWant},
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_TICK, 8'h00, 1'b1, 1'b0, NoWant},
    '{ROW_REG,  fbs_pkg::REG_STOP_LEVEL,   9'd0, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0,
      NoWant},
    '{ROW_REG,  fbs_pkg::REG_PAUSE_LEVEL,  9'd1, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0,
      NoWant},
    '{ROW_REG,  fbs_pkg::REG_RESUME_LEVEL, 9'd0, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0,
      NoWant},
    // push at count 1: stop and pause both trip
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_BYTE, 8'h5A, 1'b0, 1'b0, NoWant},
    // paused and above resume level: refused
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_BYTE, 8'hC3, 1'b1, 1'b0, NoWant},
    '{ROW_REG,  fbs_pkg::REG_RESUME_LEVEL, 9'd511, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0,
      NoWant},
    // paused but now under resume level: resumes on the byte and pauses again
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_BYTE, 8'h81, 1'b0, 1'b0, NoWant},
    '{ROW_REG,  fbs_pkg::REG_RESUME_LEVEL, 9'd2, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0,
      NoWant},
    // wide write, masks down to invert off
    '{ROW_REG,  fbs_pkg::REG_INVERT_BITS, 9'h1FE, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0,
      NoWant},
    // six ticks finish the 0xFF, the seventh pops and resumes on the tick
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0, NoWant},
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_TICK, 8'h00, 1'b1, 1'b0, NoWant},
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0, NoWant},
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_TICK, 8'h00, 1'b1, 1'b0, NoWant},
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0, NoWant},
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0, NoWant},
    '{ROW_BEAT, fbs_pkg::REG_STOP_LEVEL, 9'd0, fbs_pkg::ACT_TICK, 8'h00, 1'b1, 1'b0, NoWant},
    '{ROW_REG,  fbs_pkg::REG_STOP_LEVEL,  9'd256, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0,
      NoWant},
    '{ROW_REG,  fbs_pkg::REG_PAUSE_LEVEL, 9'd256, fbs_pkg::ACT_TICK, 8'h00, 1'b0, 1'b0,
      NoWant}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fbs_in_if  in_if ();
  fbs_out_if out_if ();
  fbs_cfg_if cfg_if ();

  fifo_bit_serializer_flow_ctrl #(
    .FIFO_DEPTH(FifoDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local model of the serialiser. Updated once per accepted input beat.
  // --------------------------------------------------------------------------
  logic [fbs_pkg::ByteW-1:0]   queue_mirror [FifoDepth];
  int unsigned                 rd_ptr = 0;
  int unsigned                 wr_ptr = 0;
  int unsigned                 held = 0;
  logic [fbs_pkg::ByteW-1:0]   shifter = '0;
  int unsigned                 bits_left = 0;
  logic                        paused = 1'b0;
  logic                        send_ok = 1'b1;
  logic                        key_on = 1'b0;
  logic                        line_hi = 1'b1;

  logic [fbs_pkg::LevelW-1:0]  stop_lvl = fbs_pkg::StopLevelRst;
  logic [fbs_pkg::LevelW-1:0]  pause_lvl = fbs_pkg::PauseLevelRst;
  logic [fbs_pkg::LevelW-1:0]  resume_lvl = fbs_pkg::ResumeLevelRst;
  logic                        invert = 1'b0;

  serial_res_t        result_q [$];
  int unsigned        n_errors = 0;
  int unsigned        beats_checked = 0;

  // sender-side idling and the long hold-off request to the receiver
  int unsigned        in_quiet = 0;
  bit                 hold_req = 1'b0;

  // a paused queue resumes, and re-grants sending, once drained far enough
  function automatic void lift_pause();
    if (paused && held <= resume_lvl) begin
      paused = 1'b0;
      send_ok = 1'b1;
    end
  endfunction

  function automatic serial_res_t predict_beat(fbs_pkg::action_e act,
                                               logic [fbs_pkg::ByteW-1:0] b,
                                               logic hk);
    serial_res_t r;
    int unsigned prior;
    r = '0;
    if (act == fbs_pkg::ACT_BYTE) begin
      if (held >= FifoDepth) begin
        // full: drop, flag, and withdraw permission
        send_ok = 1'b0;
        r.byte_refused = 1'b1;
      end else begin
        lift_pause();
        if (paused) begin
          r.byte_refused = 1'b1;
        end else begin
          prior = held;
          queue_mirror[wr_ptr] = b;
          wr_ptr = (wr_ptr + 1) % FifoDepth;
          held = prior + 1;
          send_ok = (prior < stop_lvl);
          if (prior >= pause_lvl) paused = 1'b1;
        end
      end
    end else begin
      // key is decided before the pop
      key_on = (bits_left != 0) || (held != 0) || hk;
      if (bits_left == 0 && held != 0) begin
        shifter = queue_mirror[rd_ptr];
        rd_ptr = (rd_ptr + 1) % FifoDepth;
        held = held - 1;
        bits_left = 8;
      end
      if (bits_left != 0) begin
        line_hi = ((shifter[bits_left-1] ^ invert) == 1'b0);
        r.bit_strobe = 1'b1;
        bits_left = bits_left - 1;
      end else begin
        line_hi = 1'b1;
      end
      lift_pause();
    end
    r.send_enable  = send_ok;
    r.transmit_key = key_on;
    r.data_level   = line_hi;
    r.fill_count   = fbs_pkg::LevelW'(held);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers. All drive at the falling edge; acceptance is seen at the
  // rising edge. Each task is entered and left just after a falling edge.
  // --------------------------------------------------------------------------
  task automatic send_item(input fbs_pkg::action_e act,
                           input logic [fbs_pkg::ByteW-1:0] b,
                           input logic hk, input logic typed,
                           input serial_res_t want);
    int unsigned gap;
    serial_res_t pred;
    if (in_quiet > 0) begin
      gap = 0;
      in_quiet--;
    end else begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 31) == 0) in_quiet = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.action           <= act;
    in_if.data_byte        <= b;
    in_if.host_key_request <= hk;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    // beat taken at this edge: advance the model, file the expectation
    pred = predict_beat(act, b, hk);
    result_q.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input fbs_pkg::cfg_reg_e idx,
                           input logic [fbs_pkg::CfgDatW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      fbs_pkg::REG_STOP_LEVEL:   stop_lvl = val;
      fbs_pkg::REG_PAUSE_LEVEL:  pause_lvl = val;
      fbs_pkg::REG_RESUME_LEVEL: resume_lvl = val;
      fbs_pkg::REG_INVERT_BITS:  invert = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // stop offering, let every expected beat come home, then let the pipeline
  // settle before touching the registers
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_levels(input logic [fbs_pkg::CfgDatW-1:0] stop_v,
                            input logic [fbs_pkg::CfgDatW-1:0] pause_v,
                            input logic [fbs_pkg::CfgDatW-1:0] resume_v,
                            input logic [fbs_pkg::CfgDatW-1:0] inv_v);
    wait_idle();
    write_reg(fbs_pkg::REG_STOP_LEVEL, stop_v);
    write_reg(fbs_pkg::REG_PAUSE_LEVEL, pause_v);
    write_reg(fbs_pkg::REG_RESUME_LEVEL, resume_v);
    write_reg(fbs_pkg::REG_INVERT_BITS, inv_v);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t beat %0d: %s", $realtime, beats_checked, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_check
    serial_res_t got;
    serial_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.send_enable  = out_if.send_enable;
      got.transmit_key = out_if.transmit_key;
      got.data_level   = out_if.data_level;
      got.bit_strobe   = out_if.bit_strobe;
      got.byte_refused = out_if.byte_refused;
      got.fill_count   = out_if.fill_count;
      if (result_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = result_q.pop_front();
        check_field("send_enable",  32'(got.send_enable),  32'(want.send_enable));
        check_field("transmit_key", 32'(got.transmit_key), 32'(want.transmit_key));
        check_field("data_level",   32'(got.data_level),   32'(want.data_level));
        check_field("bit_strobe",   32'(got.bit_strobe),   32'(want.bit_strobe));
        check_field("byte_refused", 32'(got.byte_refused), 32'(want.byte_refused));
        check_field("fill_count",   32'(got.fill_count),   32'(want.fill_count));
      end
      beats_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random ready gaps with quiet stretches, and one long
  // hold-off on request so the pipeline backs up into the input channel.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    int unsigned quiet;
    out_if.ready = 1'b0;
    quiet = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = 120;
      end else if (quiet > 0) begin
        gap = 0;
        quiet--;
      end else begin
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 31) == 0) quiet = $urandom_range(10, 40);
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned byte_pct;
    in_if.valid            = 1'b0;
    in_if.action           = fbs_pkg::ACT_BYTE;
    in_if.data_byte        = '0;
    in_if.host_key_request = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = fbs_pkg::REG_STOP_LEVEL;
    cfg_if.data            = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table: register rows wait for the pipe to empty first
    for (int i = 0; i < NumRows; i++) begin
      if (StimTable[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(StimTable[i].reg_idx, StimTable[i].reg_val);
      end else begin
        send_item(StimTable[i].act, StimTable[i].data, StimTable[i].hk,
                  StimTable[i].typed, StimTable[i].want);
      end
    end

    // Fill to the brim with no ticks: send permission drops on the last
    // push, pointers wrap, and bytes at a full queue are refused.
    set_levels(9'd255, 9'd511, 9'd511, 9'd0);
    for (int k = 0; k < 400 && held < FifoDepth; k++)
      send_item(fbs_pkg::ACT_BYTE, 8'($urandom), 1'($urandom), 1'b0, NoWant);
    repeat (3) send_item(fbs_pkg::ACT_BYTE, 8'($urandom), 1'($urandom), 1'b0, NoWant);
    repeat (20) send_item(fbs_pkg::ACT_TICK, 8'($urandom), 1'($urandom), 1'b0, NoWant);

    // random phases, each under its own level setting
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          set_levels(fbs_pkg::StopLevelRst, fbs_pkg::PauseLevelRst,
                     fbs_pkg::ResumeLevelRst, 9'd0);
          byte_pct = 60;
        end
        1: begin
          // any push pauses, and only an empty queue resumes
          set_levels(9'd0, 9'd0, 9'd0, 9'd1);
          byte_pct = 40;
        end
        2: begin
          // levels never reached: only a full queue refuses
          set_levels(9'd256, 9'd256, 9'd256, 9'd0);
          byte_pct = 85;
        end
        3: begin
          set_levels(9'd511, 9'd511, 9'd511, 9'd1);
          byte_pct = 90;
        end
        7: begin
          set_levels(9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
          byte_pct = $urandom_range(30, 90);
        end
        default: begin
          // small levels so the hysteresis cycles many times per phase
          set_levels(9'($urandom_range(0, 60)), 9'($urandom_range(0, 80)),
                     9'($urandom_range(0, 60)), 9'($urandom));
          byte_pct = $urandom_range(20, 90);
        end
      endcase
      for (int n = 0; n < PhaseBeats; n++) begin
        // receiver stalls while the byte-heavy phase keeps pushing
        if (p == 2 && n == 40) hold_req = 1'b1;
        send_item(($urandom_range(0, 99) < byte_pct) ? fbs_pkg::ACT_BYTE : fbs_pkg::ACT_TICK,
                  8'($urandom), 1'($urandom), 1'b0, NoWant);
      end
    end

    wait_idle();
    if (n_errors == 0) begin
      $display("fifo_bit_serializer_flow_ctrl test passed");
    end else begin
      $display("fifo_bit_serializer_flow_ctrl test failed");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin : watchdog
    #3000000;
    $display("fifo_bit_serializer_flow_ctrl test failed");
    $finish;
  end

endmodule : tb
`default_nettype wire
